@@ rtl/fatts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatts_pkg
// Shared types, constants and calendar tables for the FAT timestamp converter.
// ----------------------------------------------------------------------------
package fatts_pkg;

    localparam int DATA_W  = 72;
    localparam int TZ_W    = 12;
    localparam int STAMP_W = 32;
    localparam int SECS_W  = 33;

    localparam logic [11:0] DIV_MIN       = 12'd60;
    localparam logic [11:0] DIV_DAY       = 12'd1440;
    // reciprocals scaled by 2^35: 1/15 after a shift by 2, 1/45 after a shift by 5
    localparam logic [31:0] RECIP_MIN     = 32'd2290649225;
    localparam logic [31:0] RECIP_DAY     = 32'd763549742;
    localparam logic [29:0] MIN_LO        = 30'd5258880;
    localparam logic [29:0] MIN_HI        = 30'd72580320;
    localparam logic [15:0] DAYS_TO_1980  = 16'd3652;
    localparam logic [15:0] DAYS_DAY0     = 16'd3651;
    localparam logic [6:0]  YEAR_2100     = 7'd120;
    localparam logic [3:0]  MON_FEB       = 4'd2;
    localparam logic [8:0]  LEAP_DOY      = 9'd59;
    localparam logic [8:0]  FEB29_CODE    = {4'd2, 5'd29};

    localparam logic [3:0]  CYC_YEAR      = 4'd7;
    localparam logic [2:0]  YEAR_TOP_BIT  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAYS,
        S_MINS,
        S_SECS,
        S_DIV_SEC,
        S_TZ,
        S_DIV_DAY,
        S_SPLIT,
        S_DIV_HOUR,
        S_HM,
        S_YEAR,
        S_DOY,
        S_PACK,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DAYS,
        OP_MINS,
        OP_SECS,
        OP_DIV,
        OP_TZ,
        OP_SPLIT,
        OP_HM,
        OP_YEAR,
        OP_DOY,
        OP_PACK,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] bit_idx;
    } t_cmd;

    typedef struct packed {
        logic range_err;
    } t_sts;

    // days before the first of each month, non-leap year
    function automatic logic [8:0] cum_days(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // year counted from 1980
    function automatic logic is_leap(input logic [6:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_2100);
    endfunction

    // days from 1980-01-01 to january 1st of the given year
    function automatic logic [15:0] year_start(input logic [6:0] y);
        logic [15:0] base;
        logic [15:0] leaps;
        base  = 16'(y) * 16'd365;
        leaps = 16'((8'(y) + 8'd3) >> 2);
        if (y > YEAR_2100) begin
            leaps = leaps - 16'd1;
        end
        return base + leaps;
    endfunction

endpackage

@@ rtl/fatts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatts_ctrl
// Sequencer for the timestamp converter: steps the datapath through either
// conversion direction and owns the stream handshakes.
// ----------------------------------------------------------------------------
module fatts_ctrl
    import fatts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_kind,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       r_m_valid;
    logic       n_m_valid;
    logic       out_free;

    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_kind ? S_DIV_SEC : S_DAYS;
                end
            end
            S_DAYS:  n_state = S_MINS;
            S_MINS:  n_state = S_SECS;
            S_SECS:  n_state = S_DONE;
            S_DIV_SEC: n_state = S_TZ;
            S_TZ:    n_state = S_DIV_DAY;
            S_DIV_DAY: begin
                if (i_sts.range_err) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: n_state = S_DIV_HOUR;
            S_DIV_HOUR: n_state = S_HM;
            S_HM:    n_state = S_YEAR;
            S_YEAR: begin
                if (r_cnt == CYC_YEAR - 4'd1) begin
                    n_state = S_DOY;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_DOY:   n_state = S_PACK;
            S_PACK:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands and handshakes
    always_comb begin
        o_cmd.op      = OP_IDLE;
        o_cmd.bit_idx = YEAR_TOP_BIT - r_cnt[2:0];
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_s_tvalid ? OP_LOAD : OP_IDLE;
            S_DAYS:     o_cmd.op = OP_DAYS;
            S_MINS:     o_cmd.op = OP_MINS;
            S_SECS:     o_cmd.op = OP_SECS;
            S_DIV_SEC:  o_cmd.op = OP_DIV;
            S_TZ:       o_cmd.op = OP_TZ;
            S_DIV_DAY:  o_cmd.op = OP_DIV;
            S_SPLIT:    o_cmd.op = OP_SPLIT;
            S_DIV_HOUR: o_cmd.op = OP_DIV;
            S_HM:       o_cmd.op = OP_HM;
            S_YEAR:     o_cmd.op = OP_YEAR;
            S_DOY:      o_cmd.op = OP_DOY;
            S_PACK:     o_cmd.op = OP_PACK;
            S_DONE:     o_cmd.op = out_free ? OP_OUT : OP_IDLE;
            default:    o_cmd.op = OP_IDLE;
        endcase
    end

    always_comb begin
        if ((r_state == S_DONE) && out_free) begin
            n_m_valid = 1'b1;
        end else if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = r_m_valid;

endmodule

@@ rtl/fatts_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatts_dp
// Datapath: constant divider, year search, month lookup, packing and the
// result register.
// ----------------------------------------------------------------------------
module fatts_dp
    import fatts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [TZ_W-1:0]      i_cfg_wdata,
    input  t_cmd                 i_cmd,
    input  logic                 i_kind,
    input  logic [STAMP_W-1:0]   i_dos_stamp,
    input  logic [SECS_W-1:0]    i_unix_seconds,
    output t_sts                 o_sts,
    output logic [SECS_W-1:0]    o_seconds_out,
    output logic [STAMP_W-1:0]   o_dos_out,
    output logic                 o_range_error
);

    logic [TZ_W-1:0]    r_tz;

    logic               r_kind,    n_kind;
    logic               r_err,     n_err;
    logic [STAMP_W-1:0] r_stamp,   n_stamp;
    logic [SECS_W-1:0]  r_num,     n_num;
    logic               r_dsel,    n_dsel;
    logic [SECS_W-1:0]  r_acc,     n_acc;
    logic [4:0]         r_sec2,    n_sec2;
    logic [5:0]         r_min,     n_min;
    logic [4:0]         r_hour,    n_hour;
    logic [15:0]        r_doy,     n_doy;
    logic [6:0]         r_year,    n_year;
    logic [STAMP_W-1:0] r_word,    n_word;
    logic [SECS_W-1:0]  r_sec_out, n_sec_out;
    logic [STAMP_W-1:0] r_dos_out, n_dos_out;
    logic               r_err_out, n_err_out;

    logic [30:0]        div_opnd;
    logic [31:0]        div_recip;
    logic [62:0]        div_prod;
    logic [SECS_W-1:0]  div_quo;
    logic [5:0]         rem_min;
    logic [10:0]        rem_day;

    logic [6:0]         k0_year;
    logic [3:0]         k0_mon;
    logic [15:0]        days_k0;
    logic [26:0]        day_min;
    logic [11:0]        hm;
    logic [27:0]        mins_k0;
    logic [SECS_W-1:0]  secs_k0;

    logic [29:0]        mins_k1;
    logic               mins_err;
    logic [6:0]         year_cand;
    logic               leap_y;
    logic [8:0]         doy_adj;
    logic [3:0]         mon0;
    logic [8:0]         day_ofs;
    logic [8:0]         dcode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz <= '0;
        end else if (i_cfg_wen) begin
            r_tz <= i_cfg_wdata;
        end
    end

    // quotient by 60 or 1440 via a reciprocal multiply, remainder in the next step
    assign div_opnd  = r_dsel ? {9'b0, r_num[26:5]} : r_num[32:2];
    assign div_recip = r_dsel ? RECIP_DAY : RECIP_MIN;
    assign div_prod  = 63'(div_opnd) * 63'(div_recip);
    assign div_quo   = {5'b0, div_prod[62:35]};
    assign rem_min   = r_acc[5:0] - 6'(r_num[5:0] * DIV_MIN[5:0]);
    assign rem_day   = r_acc[10:0] - 11'(r_num[10:0] * DIV_DAY[10:0]);

    // packed word to seconds
    assign k0_year = r_stamp[31:25];
    assign k0_mon  = r_stamp[24:21];
    assign days_k0 = DAYS_DAY0 + year_start(k0_year)
                   + 16'(is_leap(k0_year) && (k0_mon > MON_FEB))
                   + 16'(cum_days(k0_mon)) + 16'(r_stamp[20:16]);
    assign day_min = 27'(r_acc[15:0]) * 27'd1440;
    assign hm      = 12'(12'(r_stamp[15:11]) * 12'd60) + 12'(r_stamp[10:5]);
    assign mins_k0 = 28'(day_min) + 28'(hm) + {{16{r_tz[TZ_W-1]}}, r_tz};
    assign secs_k0 = 33'(r_acc[27:0]) * 33'd60 + {27'b0, r_stamp[4:0], 1'b0};

    // seconds to packed word
    assign mins_k1  = {2'b00, r_num[27:0]} - {{18{r_tz[TZ_W-1]}}, r_tz};
    assign mins_err = ($signed(mins_k1) < $signed(MIN_LO))
                   || ($signed(mins_k1) >= $signed(MIN_HI));
    assign year_cand = r_year | (7'd1 << i_cmd.bit_idx);
    assign leap_y    = is_leap(r_year);
    assign doy_adj   = (leap_y && (r_doy[8:0] > LEAP_DOY)) ? r_doy[8:0] - 9'd1 : r_doy[8:0];

    always_comb begin
        mon0 = '0;
        for (int k = 0; k < 11; k++) begin
            if (cum_days(4'(k + 2)) <= doy_adj) begin
                mon0 = mon0 + 4'd1;
            end
        end
    end

    assign day_ofs = doy_adj - cum_days(mon0 + 4'd1);
    assign dcode   = (leap_y && (r_doy[8:0] == LEAP_DOY))
                   ? FEB29_CODE : {mon0 + 4'd1, 5'(day_ofs + 9'd1)};

    always_comb begin
        n_kind    = r_kind;
        n_err     = r_err;
        n_stamp   = r_stamp;
        n_num     = r_num;
        n_dsel    = r_dsel;
        n_acc     = r_acc;
        n_sec2    = r_sec2;
        n_min     = r_min;
        n_hour    = r_hour;
        n_doy     = r_doy;
        n_year    = r_year;
        n_word    = r_word;
        n_sec_out = r_sec_out;
        n_dos_out = r_dos_out;
        n_err_out = r_err_out;
        unique case (i_cmd.op)
            OP_LOAD: begin
                n_kind  = i_kind;
                n_err   = 1'b0;
                n_stamp = i_dos_stamp;
                n_num   = i_unix_seconds;
                n_dsel  = 1'b0;
            end
            OP_DAYS: n_acc = {17'b0, days_k0};
            OP_MINS: n_acc = {5'b0, mins_k0};
            OP_SECS: n_acc = secs_k0;
            OP_DIV: begin
                n_num = div_quo;
                n_acc = r_num;
            end
            OP_TZ: begin
                n_sec2 = rem_min[5:1];
                n_err  = mins_err;
                n_num  = {6'b0, mins_k1[26:0]};
                n_dsel = 1'b1;
            end
            OP_SPLIT: begin
                n_doy  = r_num[15:0] - DAYS_TO_1980;
                n_num  = {22'b0, rem_day};
                n_dsel = 1'b0;
                n_year = '0;
            end
            OP_HM: begin
                n_hour = r_num[4:0];
                n_min  = rem_min;
            end
            OP_YEAR: begin
                if (year_start(year_cand) <= r_doy) begin
                    n_year = year_cand;
                end
            end
            OP_DOY:  n_doy = r_doy - year_start(r_year);
            OP_PACK: n_word = {r_year, dcode, r_hour, r_min, r_sec2};
            OP_OUT: begin
                n_sec_out = r_kind ? '0 : r_acc;
                n_dos_out = (r_kind && !r_err) ? r_word : '0;
                n_err_out = r_kind && r_err;
            end
            OP_IDLE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_err     <= n_err;
        r_stamp   <= n_stamp;
        r_num     <= n_num;
        r_dsel    <= n_dsel;
        r_acc     <= n_acc;
        r_sec2    <= n_sec2;
        r_min     <= n_min;
        r_hour    <= n_hour;
        r_doy     <= n_doy;
        r_year    <= n_year;
        r_word    <= n_word;
        r_sec_out <= n_sec_out;
        r_dos_out <= n_dos_out;
        r_err_out <= n_err_out;
    end

    assign o_sts.range_err = r_err;
    assign o_seconds_out   = r_sec_out;
    assign o_dos_out       = r_dos_out;
    assign o_range_error   = r_err_out;

endmodule

@@ rtl/fat_timestamp_conversion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_timestamp_conversion
// Converts between the packed FAT date-time word and seconds since 1970.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A packed-word-to-seconds transfer steps
// through the day, minute and second sums. In a seconds-to-packed-word transfer
// the divisions by 60 and 1440 and the hour split each use a reciprocal
// multiply, with the remainder worked out in the step that follows, and the
// year is found by a 7-step binary search over computed year-start day counts;
// out-of-range seconds go to the output straight after the division by 1440.
// o_s_axis_tready rises together with o_m_axis_tvalid, as the result enters the
// output register, and the output register holds the result until the sink
// takes it. The time-zone register may be written only while no item is in
// flight.
module fat_timestamp_conversion
    import fatts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [TZ_W-1:0]   i_cfg_wdata,     // tz_minutes_west, signed
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [DATA_W-1:0] i_s_axis_tdata,  // dos_stamp[31:0], unix_seconds[64:32]
    input  logic              i_s_axis_tuser,  // kind
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [DATA_W-1:0] o_m_axis_tdata,  // seconds_out[32:0], dos_out[64:33]
    output logic              o_m_axis_tuser   // range_error
);

    t_cmd               cmd;
    t_sts               sts;
    logic [SECS_W-1:0]  seconds_out;
    logic [STAMP_W-1:0] dos_out;

    fatts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fatts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .i_kind         (i_s_axis_tuser),
        .i_dos_stamp    (i_s_axis_tdata[STAMP_W-1:0]),
        .i_unix_seconds (i_s_axis_tdata[STAMP_W+SECS_W-1:STAMP_W]),
        .o_sts          (sts),
        .o_seconds_out  (seconds_out),
        .o_dos_out      (dos_out),
        .o_range_error  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{(DATA_W-SECS_W-STAMP_W){1'b0}}, dos_out, seconds_out};

endmodule

@@ tb/sv/fat_timestamp_conversion_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_timestamp_conversion_tb
// Self-checking bench for the FAT date-time converter. A table of directed
// vectors covers range limits, leap days, malformed date fields and
// time-zone extremes. It is followed by random phases, each under its own
// time-zone setting, mixing well-formed stamps, in-range and boundary seconds
// and raw values. Every result is checked against its table entry or an in-bench
// calendar model, with random gaps on both streams and long sink hold-offs.
// ----------------------------------------------------------------------------
module fat_timestamp_conversion_tb;
    import fatts_pkg::*;

    localparam logic TO_SECONDS = 1'b0;
    localparam logic TO_DOS     = 1'b1;

    localparam longint FIRST_DAY = 10 * 365 + 2;    // 1980-01-01
    localparam longint END_DAY   = 50403;           // 2108-01-01
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     N_PHASES     = 7;
    localparam int     PHASE_ITEMS  = 72;

    localparam int DAYS_BEFORE [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                        304, 334, 0, 0, 0};
    localparam int TZ_PHASES [5] = '{0, 1440, -1440, -2048, 2047};

    typedef struct packed {
        logic [32:0] seconds;
        logic [31:0] dos;
        logic        range_err;
    } conversion_t;

    typedef struct packed {
        logic signed [TZ_W-1:0] tz;
        logic                   kind;
        logic [31:0]            stamp;
        logic [32:0]            unix_secs;
        logic                   known;
        conversion_t            want;
    } vector_t;

    localparam int N_VECTORS = 26;
    localparam vector_t VECTORS [N_VECTORS] = '{
        '{12'sd0, TO_SECONDS, 32'h0021_0000, 33'd0, 1'b1, '{33'd315532800, 32'd0, 1'b0}},
        '{12'sd0, TO_SECONDS, 32'h0000_0000, 33'h1_FFFF_FFFF, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'hFFFF_FFFF, 33'd0, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'h2800_6000, 33'd0, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'h29BF_0000, 33'd0, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'h01E0_FFFF, 33'd0, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'h285D_0000, 33'd0, 1'b1, '{33'd951782400, 32'd0, 1'b0}},
        '{12'sd0, TO_DOS, 32'd0, 33'd951782400, 1'b1, '{33'd0, 32'h285D_0000, 1'b0}},
        '{12'sd0, TO_DOS, 32'd0, 33'd4107542400, 1'b0, '0},
        '{12'sd0, TO_DOS, 32'd0, 33'd4107542399, 1'b0, '0},
        '{12'sd0, TO_SECONDS, 32'hF05D_0000, 33'd0, 1'b0, '0},
        '{12'sd0, TO_DOS, 32'd0, 33'd0, 1'b1, '{33'd0, 32'd0, 1'b1}},
        '{12'sd0, TO_DOS, 32'd0, 33'h1_FFFF_FFFF, 1'b1, '{33'd0, 32'd0, 1'b1}},
        '{12'sd0, TO_DOS, 32'd0, 33'd315532799, 1'b1, '{33'd0, 32'd0, 1'b1}},
        '{12'sd0, TO_DOS, 32'd0, 33'd315532800, 1'b1, '{33'd0, 32'h0021_0000, 1'b0}},
        '{12'sd0, TO_DOS, 32'd0, 33'd4354819199, 1'b1, '{33'd0, 32'hFF9F_BF7D, 1'b0}},
        '{12'sd0, TO_DOS, 32'd0, 33'd4354819200, 1'b1, '{33'd0, 32'd0, 1'b1}},
        '{12'sd0, TO_SECONDS, 32'hFF9F_BF7D, 33'd0, 1'b1, '{33'd4354819198, 32'd0, 1'b0}},
        '{-12'sd1440, TO_DOS, 32'd0, 33'd315446400, 1'b1, '{33'd0, 32'h0021_0000, 1'b0}},
        '{-12'sd1440, TO_SECONDS, 32'h0021_0000, 33'd0, 1'b1,
          '{33'd315446400, 32'd0, 1'b0}},
        '{12'sd1440, TO_DOS, 32'd0, 33'd315532800, 1'b1, '{33'd0, 32'd0, 1'b1}},
        '{12'sd1440, TO_DOS, 32'd0, 33'd4354905599, 1'b1, '{33'd0, 32'hFF9F_BF7D, 1'b0}},
        '{-12'sd2048, TO_SECONDS, 32'hFFFF_FFFF, 33'd0, 1'b0, '0},
        '{-12'sd2048, TO_DOS, 32'd0, 33'd4354819200, 1'b0, '0},
        '{12'sd2047, TO_SECONDS, 32'h0000_0000, 33'd0, 1'b0, '0},
        '{12'sd2047, TO_DOS, 32'd0, 33'h1_0000_0000, 1'b0, '0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wen = 1'b0;
    logic [TZ_W-1:0]   i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata = '0;   // dos_stamp[31:0], unix_seconds[64:32]
    logic              i_s_axis_tuser = 1'b0; // kind
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;        // seconds_out[32:0], dos_out[64:33]
    logic              o_m_axis_tuser;        // range_error

    conversion_t pending_conversions [$];
    int          tz_west = 0;
    logic signed [TZ_W-1:0] tz_setting = '0;
    bit          burst_mode = 1'b0;
    int          holds_requested = 0;
    int          holds_served = 0;
    int          sink_stall = 0;
    int          failures = 0;
    int          to_seconds_count = 0;
    int          to_dos_count = 0;
    int          range_err_count = 0;
    int          tz_writes = 0;

    fat_timestamp_conversion dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic conversion_t convert_timestamp(input logic kind,
                                                      input logic [31:0] stamp,
                                                      input logic [32:0] unix_secs);
        conversion_t r;
        int          yr, mon, leaps, y, rem, mon0;
        longint      days, total, s, mins;
        logic [31:0] word;
        r = '0;
        if (kind == TO_SECONDS) begin
            yr    = int'(stamp[31:25]) + 10;
            mon   = int'(stamp[24:21]);
            leaps = (yr + 2) / 4 - (yr + 70) / 100;
            if (yr + 70 >= 100) begin
                leaps++;
            end
            // month 0 counts as before march
            if (leap_year(yr + 1970) && mon - 1 < 2) begin
                leaps--;
            end
            days  = longint'(DAYS_BEFORE[mon] + yr * 365 + leaps + int'(stamp[20:16]) - 1);
            total = ((days * 24 + longint'(stamp[15:11])) * 60 + longint'(stamp[10:5])
                     + longint'(tz_west)) * 60 + 2 * longint'(stamp[4:0]);
            r.seconds = total[32:0];
        end else begin
            s    = longint'(unix_secs);
            mins = s / 60 - longint'(tz_west);
            days = mins / 1440;
            if (mins < 0 || days < FIRST_DAY || days >= END_DAY) begin
                r.range_err = 1'b1;
                return r;
            end
            word = 32'((s % 60) / 2) + (32'(mins % 60) << 5) + (32'((mins / 60) % 24) << 11);
            rem  = int'(days - FIRST_DAY);
            y    = 0;
            while (y < 127 && rem >= (leap_year(1980 + y) ? 366 : 365)) begin
                rem -= leap_year(1980 + y) ? 366 : 365;
                y++;
            end
            if (leap_year(1980 + y) && rem == 59) begin
                word += 32'(FEB29_CODE) << 16;
            end else begin
                if (leap_year(1980 + y) && rem > 59) begin
                    rem--;
                end
                mon0 = 0;
                while (mon0 < 11 && DAYS_BEFORE[mon0 + 2] <= rem) begin
                    mon0++;
                end
                word += 32'(((mon0 + 1) << 5) + rem - DAYS_BEFORE[mon0 + 1] + 1) << 16;
            end
            word += 32'(y) << 25;
            r.dos = word;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // leaves tvalid high on return; the caller lowers it or sends again in the same step
    task automatic send_stamp(input logic kind, input logic [31:0] stamp,
                              input logic [32:0] unix_secs, input logic known,
                              input conversion_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {7'd0, unix_secs, stamp};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pending_conversions.push_back(known ? want : convert_timestamp(kind, stamp, unix_secs));
        if (kind == TO_SECONDS) begin
            to_seconds_count++;
        end else begin
            to_dos_count++;
        end
    endtask

    task automatic set_time_zone(input logic signed [TZ_W-1:0] tz);
        i_s_axis_tvalid <= 1'b0;
        while (pending_conversions.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= tz;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        tz_setting = tz;
        tz_west    = int'(tz);
        tz_writes++;
    endtask

    task automatic random_item(output logic kind, output logic [31:0] stamp,
                               output logic [32:0] unix_secs);
        int     choice;
        longint lo, span, base;
        choice    = $urandom_range(0, 9);
        stamp     = $urandom;
        unix_secs = {1'($urandom_range(0, 1)), 32'($urandom)};
        kind      = (choice < 5) ? TO_SECONDS : TO_DOS;
        if (choice < 4) begin
            stamp = {7'($urandom_range(0, 127)), 4'($urandom_range(1, 12)),
                     5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                     6'($urandom_range(0, 59)), 5'($urandom_range(0, 29))};
        end else if (choice >= 5 && choice < 8) begin
            lo        = 64'd315532800 - 172800;
            span      = 64'd4354819200 + 172800 - lo;
            unix_secs = 33'(lo + longint'($urandom) % span);
        end else if (choice == 8) begin
            // around the ends of the packed range, shifted by the zone
            base      = ($urandom_range(0, 1) ? 64'd4354819200 : 64'd315532800)
                        + longint'(tz_west) * 60;
            unix_secs = 33'(base + longint'($urandom_range(0, 7200)) - 3600);
        end
    endtask

    task automatic take_result();
        conversion_t want, got;
        got.seconds   = o_m_axis_tdata[32:0];
        got.dos       = o_m_axis_tdata[64:33];
        got.range_err = o_m_axis_tuser;
        if (got.range_err) begin
            range_err_count++;
        end
        if (pending_conversions.size() == 0) begin
            $display("%0t: unexpected transfer, seconds %0d dos %h range_error %b",
                     $time, got.seconds, got.dos, got.range_err);
            failures++;
            return;
        end
        want = pending_conversions.pop_front();
        if (got.seconds !== want.seconds) begin
            $display("%0t: seconds_out expected %0d, got %0d", $time, want.seconds, got.seconds);
            failures++;
        end
        if (got.dos !== want.dos) begin
            $display("%0t: dos_out expected %h, got %h", $time, want.dos, got.dos);
            failures++;
        end
        if (got.range_err !== want.range_err) begin
            $display("%0t: range_error expected %b, got %b", $time, want.range_err,
                     got.range_err);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            take_result();
        end
        if (holds_served != holds_requested) begin
            holds_served++;
            sink_stall = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            sink_stall = pick_gap();
            i_m_axis_tready <= (sink_stall == 0);
        end
    end

    initial begin
        int          v, phase, i, tz;
        logic        kind;
        logic [31:0] stamp;
        logic [32:0] unix_secs;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (v = 0; v < N_VECTORS; v++) begin
            if (VECTORS[v].tz != tz_setting) begin
                set_time_zone(VECTORS[v].tz);
            end
            send_stamp(VECTORS[v].kind, VECTORS[v].stamp, VECTORS[v].unix_secs,
                       VECTORS[v].known, VECTORS[v].want);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            tz = (phase < 5) ? TZ_PHASES[phase] : int'($urandom_range(0, 2880)) - 1440;
            set_time_zone(TZ_W'(tz));
            if (phase == 1 || phase == 4) begin
                holds_requested++;
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                burst_mode = (phase % 2 == 1) && (i < 24);
                random_item(kind, stamp, unix_secs);
                send_stamp(kind, stamp, unix_secs, 1'b0, '0);
            end
            burst_mode = 1'b0;
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_conversions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d stamp-to-seconds and %0d seconds-to-stamp transfers",
                 to_seconds_count, to_dos_count);
        $display("%0d results out of range, %0d time-zone writes, %0d sink hold-offs",
                 range_err_count, tz_writes, holds_served);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fatts_pkg.sv
rtl/fatts_ctrl.sv
rtl/fatts_dp.sv
rtl/fat_timestamp_conversion.sv
tb/sv/fat_timestamp_conversion_tb.sv
